[design/bir_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bir_pkg: shared constants, codes and types of the record table
// Geometry of the identifier space, operation and status codes, memory
// port bundles and the lowest-set-bit search.
// ---------------------------------------------------------------------------
package bir_pkg;

    localparam int ID_BITS     = 16;
    localparam int GROUP_SIZE  = 256;
    localparam int DATA_BITS   = 64;
    localparam int MIN_ID      = 256;
    localparam int WORD_BITS   = 32;

    localparam int NUM_IDS     = 1 << ID_BITS;
    localparam int WORD_SHIFT  = $clog2(WORD_BITS);
    localparam int GROUP_SHIFT = $clog2(GROUP_SIZE);
    localparam int WADDR_BITS  = ID_BITS - WORD_SHIFT;
    localparam int GADDR_BITS  = ID_BITS - GROUP_SHIFT;
    localparam int NUM_GROUPS  = 1 << GADDR_BITS;
    localparam int SADDR_BITS  = GADDR_BITS - WORD_SHIFT;
    localparam int CNT_BITS    = GROUP_SHIFT + 1;
    localparam int POS_BITS    = ID_BITS + 1;

    // fixed field widths of the stream items
    localparam int MODE_BITS   = 2;
    localparam int KEY_BITS    = 16;
    localparam int XDATA_BITS  = 64;
    localparam int STATUS_BITS = 2;
    localparam int TOTAL_BITS  = 17;

    localparam logic [MODE_BITS-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_FIND   = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_NEXT   = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_BADID    = 2'd2;

    // valid bitmap memory, one word of WORD_BITS entries per address
    typedef struct packed {
        logic                  we;
        logic [WADDR_BITS-1:0] waddr;
        logic [WORD_BITS-1:0]  wdata;
        logic [WADDR_BITS-1:0] raddr;
    } vw_port_t;

    // per-group entry count memory
    typedef struct packed {
        logic                  we;
        logic [GADDR_BITS-1:0] waddr;
        logic [CNT_BITS-1:0]   wdata;
        logic [GADDR_BITS-1:0] raddr;
    } gc_port_t;

    // record payload memory
    typedef struct packed {
        logic                 we;
        logic [ID_BITS-1:0]   waddr;
        logic [DATA_BITS-1:0] wdata;
        logic [ID_BITS-1:0]   raddr;
    } pl_port_t;

    // update of one group nonempty flag
    typedef struct packed {
        logic                  we;
        logic [GADDR_BITS-1:0] group;
        logic                  flag;
    } sum_upd_t;

    function automatic logic [WORD_SHIFT-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [WORD_SHIFT-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = WORD_SHIFT'(i);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[design/bir_ram.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bir_ram: simple dual-port synchronous memory
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module bir_ram #(
    parameter int AW = 8,
    parameter int DW = 8
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1 << AW) - 1];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[design/bir_summary.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bir_summary: group nonempty flags
// One flag per group in flip-flops, read a word of flags at a time for the
// next-valid search.
// ---------------------------------------------------------------------------
module bir_summary (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire bir_pkg::sum_upd_t                  upd,
    input  wire logic [bir_pkg::SADDR_BITS-1:0]     rd_sel,
    output logic      [bir_pkg::WORD_BITS-1:0]      rd_word
);

    logic [bir_pkg::NUM_GROUPS-1:0] flags_reg;
    logic [bir_pkg::NUM_GROUPS-1:0] flags_next;

    always_comb
    begin
        flags_next = flags_reg;
        if (upd.we)
        begin
            flags_next[upd.group] = upd.flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    assign rd_word = flags_reg[{rd_sel, {bir_pkg::WORD_SHIFT{1'b0}}} +: bir_pkg::WORD_BITS];

endmodule
`default_nettype wire

[design/bir_ctrl.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bir_ctrl: operation sequencer
// Clears the bitmap and group counts after reset, runs read-modify-write for
// add, remove and find, walks summary flags and bitmap words for next, holds the result.
// ---------------------------------------------------------------------------
module bir_ctrl (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // request side
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [bir_pkg::MODE_BITS-1:0]       s_mode,
    input  wire logic [bir_pkg::KEY_BITS-1:0]        s_key,
    input  wire logic [bir_pkg::XDATA_BITS-1:0]      s_data,
    // result side
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [bir_pkg::STATUS_BITS-1:0]     m_status,
    output logic      [bir_pkg::KEY_BITS-1:0]        m_id,
    output logic      [bir_pkg::XDATA_BITS-1:0]      m_data,
    output logic      [bir_pkg::TOTAL_BITS-1:0]      m_count,
    // memories
    output bir_pkg::vw_port_t                        vw,
    input  wire logic [bir_pkg::WORD_BITS-1:0]       vw_rdata,
    output bir_pkg::gc_port_t                        gc,
    input  wire logic [bir_pkg::CNT_BITS-1:0]        gc_rdata,
    output bir_pkg::pl_port_t                        pl,
    input  wire logic [bir_pkg::DATA_BITS-1:0]       pl_rdata,
    // summary flags
    output bir_pkg::sum_upd_t                        sum_upd,
    output logic      [bir_pkg::SADDR_BITS-1:0]      sum_sel,
    input  wire logic [bir_pkg::WORD_BITS-1:0]       sum_word
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_MOD  = 4'd3;
    localparam logic [3:0] S_SUM  = 4'd4;
    localparam logic [3:0] S_WRD  = 4'd5;
    localparam logic [3:0] S_WCHK = 4'd6;
    localparam logic [3:0] S_PAY  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    localparam int IW = bir_pkg::ID_BITS;
    localparam int PW = bir_pkg::POS_BITS;

    // control state
    logic [3:0]                        state_reg, state_next;
    logic [bir_pkg::WADDR_BITS-1:0]    clr_reg, clr_next;
    logic [bir_pkg::TOTAL_BITS-1:0]    total_reg, total_next;
    logic                              m_valid_reg, m_valid_next;

    // payload registers
    logic [bir_pkg::MODE_BITS-1:0]     mode_reg, mode_next;
    logic [bir_pkg::KEY_BITS-1:0]      key_reg, key_next;
    logic [bir_pkg::DATA_BITS-1:0]     data_reg, data_next;
    logic [PW-1:0]                     pos_reg, pos_next;
    logic [bir_pkg::STATUS_BITS-1:0]   res_status_reg, res_status_next;
    logic [bir_pkg::KEY_BITS-1:0]      res_id_reg, res_id_next;
    logic [bir_pkg::XDATA_BITS-1:0]    res_data_reg, res_data_next;
    logic [bir_pkg::STATUS_BITS-1:0]   m_status_reg, m_status_next;
    logic [bir_pkg::KEY_BITS-1:0]      m_id_reg, m_id_next;
    logic [bir_pkg::XDATA_BITS-1:0]    m_data_reg, m_data_next;
    logic [bir_pkg::TOTAL_BITS-1:0]    m_count_reg, m_count_next;

    // scan position fields
    logic [bir_pkg::WADDR_BITS-1:0]    pos_word;
    logic [bir_pkg::WORD_SHIFT-1:0]    pos_bit;
    logic [bir_pkg::GADDR_BITS-1:0]    pos_group;
    logic [bir_pkg::WORD_SHIFT-1:0]    grp_bit;
    logic [bir_pkg::GROUP_SHIFT-bir_pkg::WORD_SHIFT-1:0] word_in_grp;

    logic [bir_pkg::WORD_BITS-1:0]     sum_masked;
    logic [bir_pkg::WORD_BITS-1:0]     word_masked;
    logic [bir_pkg::GADDR_BITS-1:0]    sum_hit_grp;
    logic [IW-1:0]                     found_id_w;
    logic [PW-1:0]                     next_sum_base;
    logic [PW-1:0]                     next_word_base;
    logic                              hit_bit;
    logic [bir_pkg::CNT_BITS-1:0]      gc_dec;
    logic                              key_beyond;
    logic                              key_low;
    logic                              accept;
    logic                              out_free;

    assign pos_word    = pos_reg[IW-1:bir_pkg::WORD_SHIFT];
    assign pos_bit     = pos_reg[bir_pkg::WORD_SHIFT-1:0];
    assign pos_group   = pos_reg[IW-1:bir_pkg::GROUP_SHIFT];
    assign grp_bit     = pos_group[bir_pkg::WORD_SHIFT-1:0];
    assign word_in_grp = pos_reg[bir_pkg::GROUP_SHIFT-1:bir_pkg::WORD_SHIFT];
    assign sum_sel     = pos_group[bir_pkg::GADDR_BITS-1:bir_pkg::WORD_SHIFT];

    assign sum_masked  = sum_word & ({bir_pkg::WORD_BITS{1'b1}} << grp_bit);
    assign word_masked = vw_rdata & ({bir_pkg::WORD_BITS{1'b1}} << pos_bit);
    assign sum_hit_grp = {sum_sel, bir_pkg::lowest_set(sum_masked)};
    assign found_id_w  = {pos_word, bir_pkg::lowest_set(word_masked)};
    assign hit_bit     = vw_rdata[pos_bit];
    assign gc_dec      = (gc_rdata != '0) ? gc_rdata - 1'b1 : '0;

    // first id of the following summary word's groups, and first id of the next bitmap word
    assign next_sum_base  = (PW'(sum_sel) + PW'(1))
                            << (bir_pkg::GROUP_SHIFT + bir_pkg::WORD_SHIFT);
    assign next_word_base = (PW'(pos_word) + PW'(1)) << bir_pkg::WORD_SHIFT;

    assign key_beyond = (32'(s_key) >= bir_pkg::NUM_IDS);
    assign key_low    = (32'(s_key) < bir_pkg::MIN_ID);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        total_next      = total_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        mode_next       = mode_reg;
        key_next        = key_reg;
        data_next       = data_reg;
        pos_next        = pos_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_data_next   = res_data_reg;
        m_status_next   = m_status_reg;
        m_id_next       = m_id_reg;
        m_data_next     = m_data_reg;
        m_count_next    = m_count_reg;

        // memory read addresses follow the scan position by default
        vw.raddr = pos_word;
        gc.raddr = pos_group;
        pl.raddr = pos_reg[IW-1:0];

        vw.we    = 1'b0;
        vw.waddr = pos_word;
        vw.wdata = vw_rdata;
        gc.we    = 1'b0;
        gc.waddr = pos_group;
        gc.wdata = gc_rdata;
        pl.we    = 1'b0;
        pl.waddr = pos_reg[IW-1:0];
        pl.wdata = data_reg;
        sum_upd.we    = 1'b0;
        sum_upd.group = pos_group;
        sum_upd.flag  = 1'b1;

        case (state_reg)
            S_CLR:
            begin
                vw.we    = 1'b1;
                vw.waddr = clr_reg;
                vw.wdata = '0;
                gc.we    = 1'b1;
                gc.waddr = clr_reg[bir_pkg::GADDR_BITS-1:0];
                gc.wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next     = s_mode;
                    key_next      = s_key;
                    data_next     = s_data[bir_pkg::DATA_BITS-1:0];
                    res_id_next   = s_key;
                    res_data_next = '0;
                    if (key_beyond)
                    begin
                        pos_next = {1'b1, {IW{1'b0}}};
                    end
                    else
                    begin
                        pos_next = {1'b0, s_key[IW-1:0]};
                    end
                    if (s_mode == bir_pkg::MODE_NEXT)
                    begin
                        state_next = S_SUM;
                    end
                    else if (key_low)
                    begin
                        res_status_next = bir_pkg::ST_BADID;
                        state_next      = S_OUT;
                    end
                    else if (key_beyond)
                    begin
                        res_status_next = bir_pkg::ST_NOTFOUND;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end

            S_RD:
            begin
                state_next = S_MOD;
            end

            S_MOD:
            begin
                state_next      = S_OUT;
                res_status_next = bir_pkg::ST_OK;
                res_data_next   = bir_pkg::XDATA_BITS'(pl_rdata);
                case (mode_reg)
                    bir_pkg::MODE_ADD:
                    begin
                        res_data_next = bir_pkg::XDATA_BITS'(data_reg);
                        pl.we         = 1'b1;
                        if (!hit_bit)
                        begin
                            vw.we               = 1'b1;
                            vw.wdata[pos_bit]   = 1'b1;
                            gc.we               = 1'b1;
                            gc.wdata            = gc_rdata + 1'b1;
                            sum_upd.we          = 1'b1;
                            total_next          = total_reg + 1'b1;
                        end
                    end
                    bir_pkg::MODE_REMOVE:
                    begin
                        if (!hit_bit)
                        begin
                            res_status_next = bir_pkg::ST_NOTFOUND;
                            res_data_next   = '0;
                        end
                        else
                        begin
                            vw.we             = 1'b1;
                            vw.wdata[pos_bit] = 1'b0;
                            gc.we             = 1'b1;
                            gc.wdata          = gc_dec;
                            // group goes empty: drop its summary flag
                            sum_upd.we        = (gc_dec == '0);
                            sum_upd.flag      = 1'b0;
                            if (total_reg != '0)
                            begin
                                total_next = total_reg - 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        if (!hit_bit)
                        begin
                            res_status_next = bir_pkg::ST_NOTFOUND;
                            res_data_next   = '0;
                        end
                    end
                endcase
            end

            S_SUM:
            begin
                if (pos_reg[IW])
                begin
                    res_status_next = bir_pkg::ST_NOTFOUND;
                    res_id_next     = '0;
                    res_data_next   = '0;
                    state_next      = S_OUT;
                end
                else if (|sum_masked)
                begin
                    if (sum_hit_grp != pos_group)
                    begin
                        pos_next = {1'b0, sum_hit_grp, {bir_pkg::GROUP_SHIFT{1'b0}}};
                    end
                    state_next = S_WRD;
                end
                else
                begin
                    pos_next = next_sum_base;
                end
            end

            S_WRD:
            begin
                state_next = S_WCHK;
            end

            S_WCHK:
            begin
                pl.raddr = found_id_w;
                if (|word_masked)
                begin
                    res_id_next = bir_pkg::KEY_BITS'(found_id_w);
                    state_next  = S_PAY;
                end
                else
                begin
                    pos_next = next_word_base;
                    // leaving the group: back to the summary flags
                    if (&word_in_grp)
                    begin
                        state_next = S_SUM;
                    end
                    else
                    begin
                        state_next = S_WRD;
                    end
                end
            end

            S_PAY:
            begin
                res_status_next = bir_pkg::ST_OK;
                res_data_next   = bir_pkg::XDATA_BITS'(pl_rdata);
                state_next      = S_OUT;
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_id_next     = res_id_reg;
                    m_data_next   = res_data_reg;
                    m_count_next  = total_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            clr_reg     <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        data_reg       <= data_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_data_reg   <= res_data_next;
        m_status_reg   <= m_status_next;
        m_id_reg       <= m_id_next;
        m_data_reg     <= m_data_next;
        m_count_reg    <= m_count_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_id     = m_id_reg;
    assign m_data   = m_data_reg;
    assign m_count  = m_count_reg;

    // total never exceeds the number of identifiers
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= bir_pkg::TOTAL_BITS'(bir_pkg::NUM_IDS))
        else $error("record total out of range");

    // only the modify step moves the total
    a_total_only_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_MOD) |=> $stable(total_reg))
        else $error("record total changed outside modify step");

    // a group that gains an entry cannot already be full
    a_group_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD && mode_reg == bir_pkg::MODE_ADD && !hit_bit)
        |-> (gc_rdata < bir_pkg::CNT_BITS'(bir_pkg::GROUP_SIZE)))
        else $error("group count overflow on add");

    // bitmap words are only checked inside the identifier space
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRD || state_reg == S_WCHK) |-> !pos_reg[IW])
        else $error("bitmap scan past the last identifier");

endmodule
`default_nettype wire

[design/bitmap_indexed_record_table.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bitmap_indexed_record_table: direct-mapped record table with bitmaps
// Add, remove, find and next-valid queries over 16-bit identifiers.
// ---------------------------------------------------------------------------
// After reset the block sweeps the valid bitmap memory, one 32-bit word a
// cycle, with s_axis_tready low. Add, remove and find go from the accepted
// request through one read of the valid bitmap word, the group count and
// the payload, one write back, and the output register. Identifiers below
// 256 skip the memory steps and go straight to the output register. Next
// looks at 32-group summary words (at most 8 per pass), then reads bitmap
// words of a nonempty group, each one addressed in S_WRD and checked in
// S_WCHK, and then reads the payload of the identifier found.
// One request is in flight at a time; a finished result waits in the output
// register while the next request is taken.
module bitmap_indexed_record_table (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [79:0]  s_axis_tdata,   // key_id[15:0], record_data[79:16]
    input  wire logic [1:0]   s_axis_tuser,   // mode[1:0]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic      [103:0] m_axis_tdata,   // found_id[15:0], found_data[79:16],
                                              // record_count[96:80], zero pad
    output logic      [1:0]   m_axis_tuser    // status[1:0]
);

    bir_pkg::vw_port_t vw;
    bir_pkg::gc_port_t gc;
    bir_pkg::pl_port_t pl;
    bir_pkg::sum_upd_t sum_upd;

    logic [bir_pkg::WORD_BITS-1:0]   vw_rdata;
    logic [bir_pkg::CNT_BITS-1:0]    gc_rdata;
    logic [bir_pkg::DATA_BITS-1:0]   pl_rdata;
    logic [bir_pkg::SADDR_BITS-1:0]  sum_sel;
    logic [bir_pkg::WORD_BITS-1:0]   sum_word;

    logic [bir_pkg::STATUS_BITS-1:0] m_status;
    logic [bir_pkg::KEY_BITS-1:0]    m_id;
    logic [bir_pkg::XDATA_BITS-1:0]  m_data;
    logic [bir_pkg::TOTAL_BITS-1:0]  m_count;

    bir_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_mode   (s_axis_tuser),
        .s_key    (s_axis_tdata[15:0]),
        .s_data   (s_axis_tdata[79:16]),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_status (m_status),
        .m_id     (m_id),
        .m_data   (m_data),
        .m_count  (m_count),
        .vw       (vw),
        .vw_rdata (vw_rdata),
        .gc       (gc),
        .gc_rdata (gc_rdata),
        .pl       (pl),
        .pl_rdata (pl_rdata),
        .sum_upd  (sum_upd),
        .sum_sel  (sum_sel),
        .sum_word (sum_word)
    );

    bir_summary u_summary (
        .clk     (clk),
        .rst_n   (rst_n),
        .upd     (sum_upd),
        .rd_sel  (sum_sel),
        .rd_word (sum_word)
    );

    // entry valid bitmap
    bir_ram #(
        .AW (bir_pkg::WADDR_BITS),
        .DW (bir_pkg::WORD_BITS)
    ) u_valid_ram (
        .clk   (clk),
        .we    (vw.we),
        .waddr (vw.waddr),
        .wdata (vw.wdata),
        .raddr (vw.raddr),
        .rdata (vw_rdata)
    );

    // valid entries per group
    bir_ram #(
        .AW (bir_pkg::GADDR_BITS),
        .DW (bir_pkg::CNT_BITS)
    ) u_count_ram (
        .clk   (clk),
        .we    (gc.we),
        .waddr (gc.waddr),
        .wdata (gc.wdata),
        .raddr (gc.raddr),
        .rdata (gc_rdata)
    );

    // record payloads
    bir_ram #(
        .AW (bir_pkg::ID_BITS),
        .DW (bir_pkg::DATA_BITS)
    ) u_payload_ram (
        .clk   (clk),
        .we    (pl.we),
        .waddr (pl.waddr),
        .wdata (pl.wdata),
        .raddr (pl.raddr),
        .rdata (pl_rdata)
    );

    assign m_axis_tdata = {7'd0, m_count, m_data, m_id};
    assign m_axis_tuser = m_status;

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for bitmap_indexed_record_table
// Drives add, remove, find and next requests on the input stream, predicts
// each answer from a shadow copy of the table and compares every output
// transfer field by field, under several sender and receiver idle patterns.
// ---------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 400;

    typedef struct packed {
        logic [bir_pkg::MODE_BITS-1:0]  mode;
        logic [bir_pkg::KEY_BITS-1:0]   key;
        logic [bir_pkg::XDATA_BITS-1:0] data;
    } lookup_req_t;

    typedef struct packed {
        logic [bir_pkg::STATUS_BITS-1:0] status;
        logic [bir_pkg::KEY_BITS-1:0]    id;
        logic [bir_pkg::XDATA_BITS-1:0]  data;
        logic [bir_pkg::TOTAL_BITS-1:0]  count;
    } lookup_rsp_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata = '0;    // key_id[15:0], record_data[79:16]
    logic [1:0]   s_axis_tuser = '0;    // mode[1:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;         // found_id[15:0], found_data[79:16],
                                        // record_count[96:80], zero pad
    logic [1:0]   m_axis_tuser;         // status[1:0]

    // shadow copy of the table
    bit                             table_valid [0:bir_pkg::NUM_IDS-1];
    logic [bir_pkg::XDATA_BITS-1:0] table_payload [0:bir_pkg::NUM_IDS-1];
    int                             group_fill [0:bir_pkg::NUM_GROUPS-1];
    int                             live_records = 0;

    lookup_req_t pending_ops [$];
    lookup_rsp_t expected_results [$];
    lookup_req_t offered;
    lookup_rsp_t predicted;
    lookup_rsp_t observed;
    logic [bir_pkg::KEY_BITS-1:0] key_pool [$];

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_requests = 0;
    int holds_done = 0;
    int hold_cnt = 0;
    int idle_cycles = 0;
    int mismatch_count = 0;

    bitmap_indexed_record_table DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    // applies one request to the shadow table and returns its answer
    function automatic lookup_rsp_t apply_lookup(input lookup_req_t op);
        lookup_rsp_t rsp;
        int          id;
        int          g;
        rsp.status = bir_pkg::ST_OK;
        rsp.id     = op.key;
        rsp.data   = '0;
        if (op.mode == bir_pkg::MODE_NEXT)
        begin
            rsp.status = bir_pkg::ST_NOTFOUND;
            rsp.id     = '0;
            id = op.key;
            while (id < bir_pkg::NUM_IDS)
            begin
                g = id / bir_pkg::GROUP_SIZE;
                if (group_fill[g] == 0)
                begin
                    id = (g + 1) * bir_pkg::GROUP_SIZE;
                end
                else if (table_valid[id])
                begin
                    rsp.status = bir_pkg::ST_OK;
                    rsp.id     = bir_pkg::KEY_BITS'(id);
                    rsp.data   = table_payload[id];
                    break;
                end
                else
                begin
                    id++;
                end
            end
        end
        else if (op.key < bir_pkg::MIN_ID)
        begin
            rsp.status = bir_pkg::ST_BADID;
        end
        else
        begin
            g = op.key / bir_pkg::GROUP_SIZE;
            if (op.mode == bir_pkg::MODE_ADD)
            begin
                if (!table_valid[op.key])
                begin
                    table_valid[op.key] = 1'b1;
                    group_fill[g]++;
                    live_records++;
                end
                table_payload[op.key] = op.data;
                rsp.data = op.data;
            end
            else if (!table_valid[op.key])
            begin
                rsp.status = bir_pkg::ST_NOTFOUND;
            end
            else
            begin
                rsp.data = table_payload[op.key];
                if (op.mode == bir_pkg::MODE_REMOVE)
                begin
                    table_valid[op.key]   = 1'b0;
                    table_payload[op.key] = '0;
                    group_fill[g]--;
                    live_records--;
                end
            end
        end
        rsp.count = bir_pkg::TOTAL_BITS'(live_records);
        return rsp;
    endfunction

    // request side: offers queued requests, predicts at each accepted transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(apply_lookup(offered));
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    offered = pending_ops.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {offered.data, offered.key};
                    s_axis_tuser  <= offered.mode;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side ready, with an occasional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (holds_done != hold_requests)
            begin
                holds_done++;
                hold_cnt = LONG_HOLD;
            end
            if (hold_cnt != 0)
            begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            observed.status = m_axis_tuser;
            observed.id     = m_axis_tdata[15:0];
            observed.data   = m_axis_tdata[79:16];
            observed.count  = m_axis_tdata[96:80];
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transfer: status %0d found_id %0d",
                       observed.status, observed.id);
                mismatch_count++;
            end
            else
            begin
                predicted = expected_results.pop_front();
                if (observed.status !== predicted.status)
                begin
                    $error("status: expected %0d, got %0d", predicted.status, observed.status);
                    mismatch_count++;
                end
                if (observed.id !== predicted.id)
                begin
                    $error("found_id: expected %0d, got %0d", predicted.id, observed.id);
                    mismatch_count++;
                end
                if (observed.data !== predicted.data)
                begin
                    $error("found_data: expected %h, got %h", predicted.data, observed.data);
                    mismatch_count++;
                end
                if (observed.count !== predicted.count)
                begin
                    $error("record_count: expected %0d, got %0d",
                           predicted.count, observed.count);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("bitmap_indexed_record_table: mismatch");
                $finish;
            end
        end
    end

    task automatic queue_op(input logic [bir_pkg::MODE_BITS-1:0] mode,
                            input logic [bir_pkg::KEY_BITS-1:0] key,
                            input logic [bir_pkg::XDATA_BITS-1:0] data);
        lookup_req_t op;
        op.mode = mode;
        op.key  = key;
        op.data = data;
        pending_ops.push_back(op);
    endtask

    // mostly well-formed traffic: removes, finds and nexts aimed at added keys
    task automatic queue_random_ops(input int n);
        lookup_req_t op;
        int          r;
        int          idx;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            op.data = {$urandom, $urandom};
            if (r < 35)
                op.mode = bir_pkg::MODE_ADD;
            else if (r < 55)
                op.mode = bir_pkg::MODE_REMOVE;
            else if (r < 78)
                op.mode = bir_pkg::MODE_FIND;
            else
                op.mode = bir_pkg::MODE_NEXT;
            r = $urandom_range(99);
            if (key_pool.size() != 0 && op.mode != bir_pkg::MODE_ADD && r < 70)
            begin
                idx = $urandom_range(key_pool.size() - 1);
                op.key = key_pool[idx];
                if (op.mode == bir_pkg::MODE_REMOVE)
                    key_pool.delete(idx);
                else if (op.mode == bir_pkg::MODE_NEXT && r < 35)
                    op.key = op.key - bir_pkg::KEY_BITS'($urandom_range(40));
            end
            else if (r < 80)
            begin
                // dense window of eight groups so groups fill and empty again
                op.key = bir_pkg::KEY_BITS'(bir_pkg::MIN_ID + $urandom_range(2047));
            end
            else if (r < 88)
            begin
                op.key = bir_pkg::KEY_BITS'($urandom_range(bir_pkg::MIN_ID - 1));
            end
            else
            begin
                op.key = bir_pkg::KEY_BITS'($urandom);
            end
            if (op.mode == bir_pkg::MODE_ADD)
                key_pool.push_back(op.key);
            pending_ops.push_back(op);
        end
    endtask

    task automatic wait_all_sent;
        while (pending_ops.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_drained;
        while (pending_ops.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, bad ids, empty entries, overwrite, group skips
        queue_op(bir_pkg::MODE_ADD,    16'd256,   '1);
        queue_op(bir_pkg::MODE_ADD,    16'd65535, '0);
        queue_op(bir_pkg::MODE_ADD,    16'd255,   64'h5a5a_a5a5_0f0f_f0f0);
        queue_op(bir_pkg::MODE_ADD,    16'd0,     '1);
        queue_op(bir_pkg::MODE_FIND,   16'd256,   '0);
        queue_op(bir_pkg::MODE_FIND,   16'd65535, '1);
        queue_op(bir_pkg::MODE_FIND,   16'd300,   '0);
        queue_op(bir_pkg::MODE_REMOVE, 16'd300,   '0);
        queue_op(bir_pkg::MODE_FIND,   16'd255,   '0);
        queue_op(bir_pkg::MODE_REMOVE, 16'd0,     '0);
        queue_op(bir_pkg::MODE_ADD,    16'd256,   64'h0123_4567_89ab_cdef);
        queue_op(bir_pkg::MODE_FIND,   16'd256,   '0);
        queue_op(bir_pkg::MODE_NEXT,   16'd0,     '0);
        queue_op(bir_pkg::MODE_NEXT,   16'd257,   '0);
        queue_op(bir_pkg::MODE_NEXT,   16'd65535, '0);
        queue_op(bir_pkg::MODE_REMOVE, 16'd65535, '0);
        queue_op(bir_pkg::MODE_NEXT,   16'd257,   '0);
        queue_op(bir_pkg::MODE_ADD,    16'd511,   64'hfedc_ba98_7654_3210);
        queue_op(bir_pkg::MODE_NEXT,   16'd257,   '0);
        queue_op(bir_pkg::MODE_REMOVE, 16'd256,   '0);
        queue_op(bir_pkg::MODE_REMOVE, 16'd511,   '0);
        queue_op(bir_pkg::MODE_NEXT,   16'd0,     '0);
        queue_op(bir_pkg::MODE_NEXT,   16'd65535, '0);
        queue_op(bir_pkg::MODE_ADD,    16'd257,   {$urandom, $urandom});
        key_pool.push_back(16'd257);
        wait_drained();

        queue_random_ops(400);
        wait_all_sent();

        sender_idle_pct = 61;
        queue_random_ops(400);
        // sender pauses until every answer is back
        wait_drained();

        sender_idle_pct = 0;
        receiver_stall_pct = 61;
        queue_random_ops(400);
        wait_all_sent();

        // long receiver hold-off while requests keep coming
        receiver_stall_pct = 0;
        hold_requests++;
        queue_random_ops(40);
        wait_all_sent();

        sender_idle_pct = 25;
        receiver_stall_pct = 25;
        queue_random_ops(400);
        wait_all_sent();

        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        queue_random_ops(360);
        wait_drained();
        repeat (50) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
        begin
            $display("bitmap_indexed_record_table: match");
        end
        else
        begin
            $display("bitmap_indexed_record_table: mismatch");
        end
        $finish;
    end

endmodule
